### src/http_response_header_parser_defines.svh
// Assertion macros used by the assertion checker file of the header parser.
// Each macro expects signals named aclk and aresetn in the using scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define HRHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define HRHP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define HRHP_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/hrhp_pkg.sv
package hrhp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PREFIX_LEN      = 5;
    localparam int NAME_CHARS      = 14;
    localparam int MIN_LENGTH      = 12;
    localparam int OUT_DATA_WIDTH  = 80;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_PREFIX,
        ST_SEEK_SPACE,
        ST_DIGIT1,
        ST_DIGIT2,
        ST_DIGIT3,
        ST_EXTRA,
        ST_DONE,
        ST_FAIL
    } status_stage_t;

    typedef enum logic [2:0] {
        LN_NAME,
        LN_SKIP,
        LN_SPACES,
        LN_DIGITS,
        LN_DONE
    } line_stage_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_NO_END  = 2'd2
    } error_code_t;

    // One classified input byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_space;
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
    } byte_class_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48; // H
            3'd1:    ch = 8'h54; // T
            3'd2:    ch = 8'h54; // T
            3'd3:    ch = 8'h50; // P
            3'd4:    ch = 8'h2F; // /
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### src/hrhp_queue.sv
module hrhp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hrhp_pkg::byte_class_t push_item,
    output logic                  full,
    input  logic                  pop,
    output hrhp_pkg::byte_class_t pop_item,
    output logic                  not_empty
);

    localparam int DEPTH = hrhp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrhp_pkg::byte_class_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/hrhp_front.sv
module hrhp_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  queue_full,
    output logic                  push,
    output hrhp_pkg::byte_class_t push_item
);

    // Accept whenever the queue has room; classify the byte on the way in.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_item.data_byte = s_tdata;
        push_item.last_byte = s_tlast;
        push_item.is_digit  = (s_tdata >= hrhp_pkg::CHAR_ZERO) &&
                              (s_tdata <= hrhp_pkg::CHAR_NINE);
        push_item.digit     = 4'(s_tdata - hrhp_pkg::CHAR_ZERO);
        push_item.is_space  = (s_tdata == hrhp_pkg::CHAR_SPACE);
        push_item.is_colon  = (s_tdata == hrhp_pkg::CHAR_COLON);
        push_item.is_cr     = (s_tdata == hrhp_pkg::CHAR_CR);
        push_item.is_lf     = (s_tdata == hrhp_pkg::CHAR_LF);
    end

endmodule

### src/hrhp_back.sv
module hrhp_back #(
    parameter int COUNT_WIDTH = hrhp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hrhp_pkg::byte_class_t               item,
    input  logic                                item_valid,
    output logic                                item_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hrhp_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

    localparam int W = COUNT_WIDTH;
    localparam logic [W-1:0] COUNT_MAX = '1;

    logic [W-1:0]              byte_counter_reg, byte_counter_next;
    hrhp_pkg::status_stage_t   status_stage_reg, status_stage_next;
    logic                      status_ok_reg, status_ok_next;
    logic [9:0]                status_accum_reg, status_accum_next;
    logic [1:0]                term_reg, term_next;
    logic                      header_found_reg, header_found_next;
    logic [W-1:0]              header_bytes_reg, header_bytes_next;
    logic [3:0]                name_idx_reg, name_idx_next;
    hrhp_pkg::line_stage_t     line_stage_reg, line_stage_next;
    logic [W-1:0]              length_accum_reg, length_accum_next;
    logic                      length_found_reg, length_found_next;
    logic                      out_valid_reg, out_valid_next;
    logic [hrhp_pkg::OUT_DATA_WIDTH-1:0] out_data_reg, out_data_next;

    // Values after this byte, before the end-of-buffer clear.
    logic [W-1:0]              count;
    hrhp_pkg::status_stage_t   upd_status_stage;
    logic                      upd_status_ok;
    logic [9:0]                upd_status_accum;
    logic [1:0]                upd_term;
    logic                      upd_header_found;
    logic [W-1:0]              upd_header_bytes;
    logic [3:0]                upd_name_idx;
    hrhp_pkg::line_stage_t     upd_line_stage;
    logic [W-1:0]              upd_length_accum;
    logic                      upd_length_found;

    logic [12:0]               st_sum;
    logic [W+3:0]              len_sum;
    logic [W-1:0]              len_added;
    logic [W-1:0]              body;
    logic [W+31:0]             hdr_ext;
    logic [W+31:0]             body_ext;
    hrhp_pkg::error_code_t     err;
    logic [9:0]                status_out;
    logic [31:0]               hdr_out;
    logic [31:0]               body_out;

    assign item_pop = item_valid && (!item.last_byte || !out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign count    = (byte_counter_reg == COUNT_MAX) ? COUNT_MAX : byte_counter_reg + 1'b1;
    assign st_sum   = {status_accum_reg, 3'b000} + {2'b00, status_accum_reg, 1'b0} +
                      13'(item.digit);
    assign len_sum  = {1'b0, length_accum_reg, 3'b000} + {3'b000, length_accum_reg, 1'b0} +
                      (W+4)'(item.digit);
    // 10*a + d exceeds the counter range exactly when the top bits are set.
    assign len_added = (len_sum[W+3:W] != 4'b0000) ? COUNT_MAX : len_sum[W-1:0];

    always_comb begin
        upd_status_stage = status_stage_reg;
        upd_status_ok    = status_ok_reg;
        upd_status_accum = status_accum_reg;
        case (status_stage_reg)
            hrhp_pkg::ST_PREFIX: begin
                if ((byte_counter_reg < W'(hrhp_pkg::PREFIX_LEN)) &&
                    (item.data_byte == hrhp_pkg::prefix_char(byte_counter_reg[2:0]))) begin
                    if (byte_counter_reg == W'(hrhp_pkg::PREFIX_LEN - 1)) begin
                        upd_status_stage = hrhp_pkg::ST_SEEK_SPACE;
                    end
                end else begin
                    upd_status_stage = hrhp_pkg::ST_FAIL;
                end
            end
            hrhp_pkg::ST_SEEK_SPACE: begin
                if (item.is_space) begin
                    upd_status_stage = hrhp_pkg::ST_DIGIT1;
                end
            end
            hrhp_pkg::ST_DIGIT1, hrhp_pkg::ST_DIGIT2, hrhp_pkg::ST_DIGIT3: begin
                if (item.is_digit) begin
                    upd_status_accum = st_sum[9:0];
                    if (status_stage_reg == hrhp_pkg::ST_DIGIT1) begin
                        upd_status_stage = hrhp_pkg::ST_DIGIT2;
                    end else if (status_stage_reg == hrhp_pkg::ST_DIGIT2) begin
                        upd_status_stage = hrhp_pkg::ST_DIGIT3;
                    end else begin
                        upd_status_stage = hrhp_pkg::ST_EXTRA;
                    end
                end else begin
                    upd_status_stage = hrhp_pkg::ST_FAIL;
                end
            end
            hrhp_pkg::ST_EXTRA: begin
                upd_status_ok    = 1'b1;
                upd_status_stage = hrhp_pkg::ST_DONE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        upd_term         = term_reg;
        upd_header_found = header_found_reg;
        upd_header_bytes = header_bytes_reg;
        upd_name_idx     = name_idx_reg;
        upd_line_stage   = line_stage_reg;
        upd_length_accum = length_accum_reg;
        upd_length_found = length_found_reg;
        if (!header_found_reg) begin
            if (term_reg[0] && item.is_lf) begin
                upd_name_idx   = '0;
                upd_line_stage = length_found_reg ? hrhp_pkg::LN_DONE : hrhp_pkg::LN_NAME;
            end else begin
                case (line_stage_reg)
                    hrhp_pkg::LN_NAME: begin
                        if (item.is_colon) begin
                            if (name_idx_reg == 4'(hrhp_pkg::NAME_CHARS)) begin
                                upd_length_found = 1'b1;
                                upd_length_accum = '0;
                                upd_line_stage   = hrhp_pkg::LN_SPACES;
                            end else begin
                                upd_line_stage = hrhp_pkg::LN_SKIP;
                            end
                        end else if ((name_idx_reg < 4'(hrhp_pkg::NAME_CHARS)) &&
                                     (item.data_byte == hrhp_pkg::name_char(name_idx_reg))) begin
                            upd_name_idx = name_idx_reg + 1'b1;
                        end else begin
                            upd_line_stage = hrhp_pkg::LN_SKIP;
                        end
                    end
                    hrhp_pkg::LN_SPACES: begin
                        if (!item.is_space) begin
                            if (item.is_digit) begin
                                upd_length_accum = len_added;
                                upd_line_stage   = hrhp_pkg::LN_DIGITS;
                            end else begin
                                upd_line_stage = hrhp_pkg::LN_DONE;
                            end
                        end
                    end
                    hrhp_pkg::LN_DIGITS: begin
                        if (item.is_digit) begin
                            upd_length_accum = len_added;
                        end else begin
                            upd_line_stage = hrhp_pkg::LN_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (item.is_cr) begin
                upd_term = (term_reg == 2'd2) ? 2'd3 : 2'd1;
            end else if (item.is_lf && (term_reg == 2'd1)) begin
                upd_term = 2'd2;
            end else if (item.is_lf && (term_reg == 2'd3)) begin
                upd_header_found = 1'b1;
                upd_term         = 2'd0;
                upd_header_bytes = count;
            end else begin
                upd_term = 2'd0;
            end
        end
    end

    // Result fields from the state as it stands after the last byte.
    always_comb begin
        body     = upd_length_found ? upd_length_accum : count - upd_header_bytes;
        hdr_ext  = {32'b0, upd_header_bytes};
        body_ext = {32'b0, body};
        if ((count < W'(hrhp_pkg::MIN_LENGTH)) || !upd_status_ok) begin
            err        = hrhp_pkg::ERR_INVALID;
            status_out = '0;
            hdr_out    = '0;
            body_out   = '0;
        end else if (!upd_header_found) begin
            err        = hrhp_pkg::ERR_NO_END;
            status_out = upd_status_accum;
            hdr_out    = '0;
            body_out   = '0;
        end else begin
            err        = hrhp_pkg::ERR_OK;
            status_out = upd_status_accum;
            hdr_out    = hdr_ext[31:0];
            body_out   = body_ext[31:0];
        end
    end

    always_comb begin
        byte_counter_next = byte_counter_reg;
        status_stage_next = status_stage_reg;
        status_ok_next    = status_ok_reg;
        status_accum_next = status_accum_reg;
        term_next         = term_reg;
        header_found_next = header_found_reg;
        header_bytes_next = header_bytes_reg;
        name_idx_next     = name_idx_reg;
        line_stage_next   = line_stage_reg;
        length_accum_next = length_accum_reg;
        length_found_next = length_found_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        if (item_pop) begin
            if (item.last_byte) begin
                byte_counter_next = '0;
                status_stage_next = hrhp_pkg::ST_PREFIX;
                status_ok_next    = 1'b0;
                status_accum_next = '0;
                term_next         = '0;
                header_found_next = 1'b0;
                header_bytes_next = '0;
                name_idx_next     = '0;
                line_stage_next   = hrhp_pkg::LN_NAME;
                length_accum_next = '0;
                length_found_next = 1'b0;
                out_valid_next    = 1'b1;
                out_data_next     = {4'b0000, body_out, hdr_out, status_out, err};
            end else begin
                byte_counter_next = count;
                status_stage_next = upd_status_stage;
                status_ok_next    = upd_status_ok;
                status_accum_next = upd_status_accum;
                term_next         = upd_term;
                header_found_next = upd_header_found;
                header_bytes_next = upd_header_bytes;
                name_idx_next     = upd_name_idx;
                line_stage_next   = upd_line_stage;
                length_accum_next = upd_length_accum;
                length_found_next = upd_length_found;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_counter_reg <= '0;
            status_stage_reg <= hrhp_pkg::ST_PREFIX;
            status_ok_reg    <= 1'b0;
            status_accum_reg <= '0;
            term_reg         <= '0;
            header_found_reg <= 1'b0;
            header_bytes_reg <= '0;
            name_idx_reg     <= '0;
            line_stage_reg   <= hrhp_pkg::LN_NAME;
            length_accum_reg <= '0;
            length_found_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            byte_counter_reg <= byte_counter_next;
            status_stage_reg <= status_stage_next;
            status_ok_reg    <= status_ok_next;
            status_accum_reg <= status_accum_next;
            term_reg         <= term_next;
            header_found_reg <= header_found_next;
            header_bytes_reg <= header_bytes_next;
            name_idx_reg     <= name_idx_next;
            line_stage_reg   <= line_stage_next;
            length_accum_reg <= length_accum_next;
            length_found_reg <= length_found_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

### src/http_response_header_parser.sv
// HTTP response header parser.
// The slave channel takes one buffer byte per beat in s_tdata, with s_tlast
// high on the final byte of the buffer. Exactly one result beat leaves on the
// master channel for each buffer, after its last byte; other bytes give none.
// The result reports the error code, the three-digit status, the header length
// through the first CR LF CR LF, and the body length (the Content-Length value,
// or the bytes after the header when no such line is seen).
// Throughput is one byte per cycle while no result stalls the back end: the
// front end classifies each byte and writes it into a two-entry queue, and
// the back end folds one byte per cycle into its running parse state. The
// last byte goes through the queue and then the output register to m_tvalid.
// When m_tready is low, the back end keeps consuming bytes of the next buffer
// and stops only at that buffer's last byte while the earlier result still
// waits; the queue then fills and s_tready drops.
// Reset (aresetn low, synchronous) clears the queue, the parse state and the
// output valid flag; the next byte after reset starts a new buffer.
module http_response_header_parser #(
    parameter int COUNT_WIDTH = hrhp_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [1:0] error_code, [11:2] status_code,
                                   // [43:12] header_length, [75:44] body_length,
                                   // [79:76] zero
);

    hrhp_pkg::byte_class_t push_item;
    hrhp_pkg::byte_class_t pop_item;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_not_empty;

    // Front end: handshake on the slave side and byte classification.
    hrhp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // The queue lets the back end stall on a waiting result without
    // stalling the byte stream at once.
    hrhp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty)
    );

    // Back end: parse state and the output register.
    hrhp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (pop_item),
        .item_valid (queue_not_empty),
        .item_pop   (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### src/http_response_header_parser_checker.sv
`include "http_response_header_parser_defines.svh"

module http_response_header_parser_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    logic [1:0] code;
    logic       stalled;
    logic       code_known;
    logic       invalid_beat;
    logic       no_end_beat;
    logic       upper_zero;
    logic       no_end_clean;

    assign code         = m_tdata[1:0];
    assign stalled      = m_tvalid && !m_tready;
    assign code_known   = (code == hrhp_pkg::ERR_OK) || (code == hrhp_pkg::ERR_INVALID) ||
                          (code == hrhp_pkg::ERR_NO_END);
    assign invalid_beat = m_tvalid && (code == hrhp_pkg::ERR_INVALID);
    assign no_end_beat  = m_tvalid && (code == hrhp_pkg::ERR_NO_END);
    assign upper_zero   = (m_tdata[79:2] == 78'd0);
    assign no_end_clean = (m_tdata[79:12] == 68'd0) && (m_tdata[11:2] <= 10'd999);

    `HRHP_ASSERT_RST(a_reset_clears_valid, !aresetn, !m_tvalid, "result valid after reset")

    `HRHP_ASSERT_NXT(a_stall_holds, stalled, m_tvalid && $stable(m_tdata), "stalled result changed")

    `HRHP_ASSERT_IMP(a_code_legal, m_tvalid, code_known, "illegal error code")

    `HRHP_ASSERT_IMP(a_invalid_zero, invalid_beat, upper_zero, "invalid result has nonzero fields")

    `HRHP_ASSERT_IMP(a_no_end_zero, no_end_beat, no_end_clean, "unterminated result carries lengths")

endmodule

bind http_response_header_parser http_response_header_parser_assertions u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/http_response_header_parser_checker.sv
// Watches both channels of the header parser, predicts the result of every
// buffer from the bytes accepted on the input channel, and compares each
// result beat with the oldest prediction.
module http_response_header_parser_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // [1:0] error_code, [11:2] status_code,
                                   // [43:12] header_length, [75:44] body_length,
                                   // [79:76] zero
    output int          mismatch_count,
    output int          results_awaited
);
    import hrhp_pkg::*;

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
    localparam logic [8*PREFIX_LEN-1:0] STATUS_PREFIX = "HTTP/";
    localparam logic [8*NAME_CHARS-1:0] LENGTH_NAME   = "Content-Length";

    typedef struct {
        error_code_t err;
        logic [9:0]  status;
        logic [31:0] header_size;
        logic [31:0] body_size;
    } parse_result_t;

    parse_result_t expected_results[$];
    int            results_seen;

    // Running parse state of the buffer in progress.
    status_stage_t status_stage;
    logic          status_valid;
    logic [9:0]    status_value;
    logic [1:0]    crlf_progress;
    logic          header_done;
    logic [63:0]   byte_count;
    logic [63:0]   header_bytes;
    logic [3:0]    name_pos;
    line_stage_t   line_stage;
    logic [63:0]   content_length;
    logic          length_seen;

    initial begin
        mismatch_count  = 0;
        results_awaited = 0;
        results_seen    = 0;
    end

    function automatic void clear_parse();
        status_stage   = ST_PREFIX;
        status_valid   = 1'b0;
        status_value   = '0;
        crlf_progress  = '0;
        header_done    = 1'b0;
        byte_count     = '0;
        header_bytes   = '0;
        name_pos       = '0;
        line_stage     = LN_NAME;
        content_length = '0;
        length_seen    = 1'b0;
    endfunction

    // Decimal accumulation that sticks at the counter maximum.
    function automatic logic [63:0] append_decimal(input logic [63:0] acc,
                                                   input logic [7:0] ch);
        logic [63:0] d;
        d = 64'(ch - CHAR_ZERO);
        if (acc > (COUNT_MAX - d) / 10) begin
            return COUNT_MAX;
        end
        return acc * 10 + d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("t=%0t result %0d: %s is %0d, expected %0d", $time, results_seen,
                 what, got, want);
        mismatch_count++;
    endtask

    task automatic take_byte(input logic [7:0] ch, input logic last);
        logic          is_digit;
        logic          name_hit;
        logic [63:0]   count;
        parse_result_t res;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        count    = (byte_count >= COUNT_MAX) ? COUNT_MAX : byte_count + 64'd1;

        case (status_stage)
            ST_PREFIX: begin
                if (byte_count >= PREFIX_LEN) begin
                    status_stage = ST_FAIL;
                end else if (ch != STATUS_PREFIX[8*(PREFIX_LEN-1-int'(byte_count)) +: 8]) begin
                    status_stage = ST_FAIL;
                end else if (byte_count == PREFIX_LEN - 1) begin
                    status_stage = ST_SEEK_SPACE;
                end
            end
            ST_SEEK_SPACE: begin
                if (ch == CHAR_SPACE) begin
                    status_stage = ST_DIGIT1;
                end
            end
            ST_DIGIT1, ST_DIGIT2, ST_DIGIT3: begin
                if (is_digit) begin
                    status_value = 10'(status_value * 10 + (ch - CHAR_ZERO));
                    status_stage = status_stage_t'(status_stage + 3'd1);
                end else begin
                    status_stage = ST_FAIL;
                end
            end
            ST_EXTRA: begin
                status_valid = 1'b1;
                status_stage = ST_DONE;
            end
            default: ;
        endcase

        if (!header_done) begin
            if (crlf_progress[0] && ch == CHAR_LF) begin
                // A new header line starts; after a match the rest are ignored.
                name_pos   = '0;
                line_stage = length_seen ? LN_DONE : LN_NAME;
            end else begin
                case (line_stage)
                    LN_NAME: begin
                        name_hit = 1'b0;
                        if (name_pos < NAME_CHARS) begin
                            name_hit = (ch == LENGTH_NAME[8*(NAME_CHARS-1-int'(name_pos)) +: 8]);
                        end
                        if (ch == CHAR_COLON) begin
                            if (name_pos == NAME_CHARS) begin
                                length_seen    = 1'b1;
                                content_length = '0;
                                line_stage     = LN_SPACES;
                            end else begin
                                line_stage = LN_SKIP;
                            end
                        end else if (name_hit) begin
                            name_pos++;
                        end else begin
                            line_stage = LN_SKIP;
                        end
                    end
                    LN_SPACES: begin
                        if (is_digit) begin
                            content_length = append_decimal(content_length, ch);
                            line_stage     = LN_DIGITS;
                        end else if (ch != CHAR_SPACE) begin
                            line_stage = LN_DONE;
                        end
                    end
                    LN_DIGITS: begin
                        if (is_digit) begin
                            content_length = append_decimal(content_length, ch);
                        end else begin
                            line_stage = LN_DONE;
                        end
                    end
                    default: ;
                endcase
            end

            if (ch == CHAR_CR) begin
                crlf_progress = (crlf_progress == 2'd2) ? 2'd3 : 2'd1;
            end else if (ch == CHAR_LF && crlf_progress == 2'd1) begin
                crlf_progress = 2'd2;
            end else if (ch == CHAR_LF && crlf_progress == 2'd3) begin
                header_done   = 1'b1;
                crlf_progress = 2'd0;
                header_bytes  = count;
            end else begin
                crlf_progress = 2'd0;
            end
        end

        byte_count = count;
        if (last) begin
            res.err         = ERR_OK;
            res.status      = status_value;
            res.header_size = header_bytes[31:0];
            res.body_size   = length_seen ? content_length[31:0] : 32'(count - header_bytes);
            if (count < MIN_LENGTH || !status_valid) begin
                res.err         = ERR_INVALID;
                res.status      = '0;
                res.header_size = '0;
                res.body_size   = '0;
            end else if (!header_done) begin
                res.err         = ERR_NO_END;
                res.header_size = '0;
                res.body_size   = '0;
            end
            expected_results.push_back(res);
            clear_parse();
        end
    endtask

    always @(posedge aclk) begin : watch
        parse_result_t want;
        if (!aresetn) begin
            clear_parse();
            expected_results.delete();
            results_awaited <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, error code", 32'(m_tdata[1:0]), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] != want.err) begin
                        report_mismatch("error code", 32'(m_tdata[1:0]), 32'(want.err));
                    end
                    if (m_tdata[11:2] != want.status) begin
                        report_mismatch("status code", 32'(m_tdata[11:2]), 32'(want.status));
                    end
                    if (m_tdata[43:12] != want.header_size) begin
                        report_mismatch("header length", m_tdata[43:12], want.header_size);
                    end
                    if (m_tdata[75:44] != want.body_size) begin
                        report_mismatch("body length", m_tdata[75:44], want.body_size);
                    end
                    if (m_tdata[79:76] != 4'd0) begin
                        report_mismatch("padding", 32'(m_tdata[79:76]), 0);
                    end
                end
                results_seen++;
            end
            results_awaited <= expected_results.size();
        end
    end

endmodule

### verif/tb.sv
// Top of the header parser testbench. This module only makes stimulus and
// gives the verdict; the checker instance beside the block predicts and
// compares every result beat.
module tb;
    import hrhp_pkg::*;

    // The receiver holds off this long once, so that the block fills up.
    localparam int LONG_HOLD_CYCLES = 300;
    // The random phase runs until both of these have been reached.
    localparam int RANDOM_BYTES_MIN   = 250;
    localparam int RANDOM_BUFFERS_MIN = 4;
    // In the directed strings this character stands for a CR LF pair.
    localparam logic [7:0] LINE_BREAK_MARK = "|";

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata  = 8'd0;
    logic                      s_tlast  = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;

    int mismatch_count;
    int results_awaited;

    // Bytes of the buffer that is being put together.
    logic [7:0] frame_q[$];
    int         bytes_sent;
    int         buffers_sent;
    // When set, the sender offers beats back to back with no gaps.
    bit         burst_mode    = 1'b0;
    // Raised by the stimulus to ask the receiver for its long hold-off.
    bit         long_hold_req = 1'b0;

    http_response_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    http_response_header_parser_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_awaited (results_awaited)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The slowest correct run stays far below this bound.
    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Appends text to the buffer; the line break mark becomes CR LF.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == LINE_BREAK_MARK) begin
                frame_q.push_back(CHAR_CR);
                frame_q.push_back(CHAR_LF);
            end else begin
                frame_q.push_back(s[i]);
            end
        end
    endtask

    // Sends the buffer one beat per byte, with tlast on the final byte. Each
    // beat is held until the handshake, and then a random gap may follow:
    // mostly none or short, now and then long.
    task automatic send_frame();
        int r;
        int gap;
        for (int i = 0; i < frame_q.size(); i++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            do @(posedge aclk); while (!s_tready);
            gap = 0;
            if (!burst_mode) begin
                r = $urandom_range(0, 99);
                if (r >= 93) begin
                    gap = $urandom_range(10, 40);
                end else if (r >= 55) begin
                    gap = $urandom_range(1, 3);
                end
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        bytes_sent += frame_q.size();
        buffers_sent++;
        frame_q.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_frame();
    endtask

    // The sender stops offering until every predicted result has left the
    // block. The counter from the checker is a registered copy, so the first
    // edge is always waited out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_awaited != 0) begin
            @(posedge aclk);
        end
    endtask

    // Receiver: ready most of the time, with short and occasional long
    // stalls, stretches of steady readiness, and one long hold-off on request.
    initial begin : receiver
        int r;
        int hold;
        int steady;
        steady = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (steady > 0) begin
                steady--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    steady = $urandom_range(30, 150);
                end
                if (r < 65) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 60);
                    repeat (hold - 1) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int kind;
        int r;
        int n_lines;
        int n_digits;
        int idx;
        int cut;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed buffers. A plain response with a Content-Length line.
        send_text("HTTP/1.1 200 OK|Content-Length: 5||hello");
        // No Content-Length line: the body is whatever follows the header.
        send_text("HTTP/1.0 404 Not Found|Server: tiny||body bytes");
        // Highest and lowest status codes; a Content-Length with no value.
        send_text("HTTP/1.1 999 X||");
        send_text("HTTP/1.1 000 Y|Content-Length:||");
        // Wrong prefix.
        send_text("HTTX/1.1 200 OK||");
        // One byte short of the minimum length.
        send_text("HTTP/ 200 x");
        // Exactly the minimum length with a complete status but no header end.
        send_text("HTTP/1 200 x");
        // Minimum length, but nothing follows the three status digits.
        send_text("HTTP/1.1 200");
        // A letter among the status digits.
        send_text("HTTP/1.1 2x0 OK||");
        // No space after the version; the first space is found in a header.
        send_text("HTTP/1.1_200|Server: a||abc");
        // Header lines without the blank line that ends them.
        send_text("HTTP/1.1 301 Moved|Location: /x|");
        // Only the first Content-Length line counts.
        send_text("HTTP/1.1 200 OK|Content-Length: 7|Content-Length: 9||abc");
        // The name match is case-sensitive and must be exact up to the colon.
        send_text("HTTP/1.1 200 OK|content-length: 5||abcdef");
        send_text("HTTP/1.1 200 OK|Content-Lengths: 5|Content-Len: 3||xy");
        // The largest value that fits, one past it, and a far larger one.
        send_text("HTTP/1.1 200 OK|Content-Length: 4294967295||");
        send_text("HTTP/1.1 200 OK|Content-Length: 4294967296||");
        send_text("HTTP/1.1 200 OK|Content-Length: 123456789012345||");
        // Several spaces before the digits and junk right after them.
        send_text("HTTP/1.1 200 OK|Content-Length:    42abc|X: 1||");
        // A matching name followed by no digits gives a body length of zero.
        send_text("HTTP/1.1 200 OK|Content-Length: abc||zz");
        // Stray CR and LF bytes before the real terminator.
        send_text("HTTP/1.1 200 OK\015\015\n\n\015\n\015\nrest");
        // A Content-Length line inside the body is not a header.
        send_text("HTTP/1.1 204 No Content||Content-Length: 8");
        // Single-byte buffers with all bits low and all bits high.
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q.push_back(8'h00);
        send_frame();
        wait_for_results();

        // The receiver holds off while short buffers arrive back to back, so a
        // result waits inside the block, the queue fills and its input stalls.
        long_hold_req = 1'b1;
        burst_mode    = 1'b1;
        repeat (12) begin
            send_text("HTTP/1.1 200 OK|Content-Length: 3||abc");
        end
        burst_mode = 1'b0;
        wait_for_results();

        // Random buffers: mostly well-formed responses with random content,
        // some of them cut short or corrupted, and some plain noise.
        bytes_sent   = 0;
        buffers_sent = 0;
        while (bytes_sent < RANDOM_BYTES_MIN || buffers_sent < RANDOM_BUFFERS_MIN) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            kind       = $urandom_range(0, 99);
            if (kind < 88) begin
                case ($urandom_range(0, 2))
                    0:       add_text("HTTP/1.1 ");
                    1:       add_text("HTTP/1.0 ");
                    default: add_text("HTTP/2 ");
                endcase
                repeat (3) frame_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                case ($urandom_range(0, 3))
                    0:       ;  // The CR right after the digits is the extra byte.
                    1:       add_text(" OK");
                    2:       add_text(" Not Found");
                    default: add_text(" Partial Content");
                endcase
                add_text("|");
                n_lines = $urandom_range(0, 3);
                repeat (n_lines) begin
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        if ($urandom_range(0, 9) == 0) begin
                            add_text("content-length:");
                        end else begin
                            add_text("Content-Length:");
                        end
                        repeat ($urandom_range(0, 3)) add_text(" ");
                        r = $urandom_range(0, 99);
                        n_digits = (r < 70) ? $urandom_range(1, 4) :
                                   (r < 85) ? 0 : $urandom_range(5, 12);
                        repeat (n_digits) frame_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                        if ($urandom_range(0, 4) == 0) begin
                            add_text(" bytes");
                        end
                    end else begin
                        case (r)
                            4:       add_text("Server: unit");
                            5:       add_text("Content-Type: text/plain");
                            6:       add_text("Content-Len: 4");
                            7:       add_text("Content-Lengths: 9");
                            8:       add_text("X-Id:7");
                            default: add_text("Connection: close");
                        endcase
                    end
                    add_text("|");
                end
                add_text("|");
                repeat ($urandom_range(0, 20)) frame_q.push_back(8'($urandom_range(0, 255)));

                // Broken responses: truncated anywhere, or with a byte or two
                // overwritten, often within the status line.
                if (kind >= 72) begin
                    if ($urandom_range(0, 1) == 1) begin
                        cut = $urandom_range(1, frame_q.size());
                        while (frame_q.size() > cut) begin
                            void'(frame_q.pop_back());
                        end
                    end else begin
                        repeat ($urandom_range(1, 2)) begin
                            idx = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) :
                                  $urandom_range(0, frame_q.size() - 1);
                            if (idx >= frame_q.size()) begin
                                idx = frame_q.size() - 1;
                            end
                            frame_q[idx] = 8'($urandom_range(0, 255));
                        end
                    end
                end
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    add_text("HTTP/");
                end
                repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
            if ($urandom_range(0, 19) == 0) begin
                wait_for_results();
            end
        end
        burst_mode = 1'b0;

        // Drain: wait for every outstanding result, then a little longer in
        // case the block produces a beat that nobody asked for.
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && results_awaited == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
